@@ rtl/lkvc_pkg.sv @@
// Package for the LRU key/value cache: data widths, codes and the control
// bundle that the top level hands to each storage cell. No dependencies.
`timescale 1ns / 1ps

package lkvc_pkg;

  // Width of keys and values.
  localparam int unsigned DataW = 32;

  // Width of the capacity register.
  localparam int unsigned CapW = 5;

  // Number of entries held by default.
  localparam int unsigned DefaultEntries = 16;

  // Capacity after reset.
  localparam logic [CapW-1:0] CapacityReset = CapW'(16);

  // Operation codes carried on mode_i.
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Value returned by a get that misses.
  localparam logic [DataW-1:0] MissValue = '1;

  // Per-cell control, driven by the top level every cycle.
  typedef struct packed {
    logic compare;  // latch a key match against the incoming request
    logic valid;    // this cell lies inside the occupied part of the chain
    logic shift;    // take the contents of the neighbouring cell
  } cell_ctrl_t;

endpackage

@@ rtl/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache: request capture, chain control and result
// registers. Depends on lkvc_pkg and lkvc_cell.
`timescale 1ns / 1ps

// The cache accepts no new request while busy_o is high. A request is accepted at a
// rising edge with start_i high and busy_o low; busy_o is then high for one cycle
// while the cells' registered key matches are resolved and the chain is updated,
// and the result appears on the result ports for exactly one cycle with done_o
// high, in the cycle after busy_o. A new request may be issued in that same
// cycle. A request passes the match flag register in every cell and then the
// update of the cell chain. Results cannot be held off, so the receiver must
// capture them while done_o is high. The capacity register may be written
// only while no request is in flight; a capacity of zero acts as one and one
// above ENTRIES acts as ENTRIES. The store is empty after reset and needs no
// clearing pass.
//
// Entries are kept in a chain ordered by recency: cell 0 holds the most recently
// used entry and cell occupancy-1 the least recently used one, so the position of
// an entry is its rank. A hit at position p moves cells 0 to p-1 one place down
// and places the hit entry in cell 0. An insertion moves every occupied cell down
// by one; when the cache is full the last occupied cell is overwritten, and its
// previous key is reported as the evicted key. Keys are unique among the live
// entries, so at most one cell matches and the hit value and position are simple
// OR reductions over the cells.

module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkvc_pkg::DefaultEntries
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: capacity register.
  input  logic                              cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0]         cfg_wdata_i,
  // Request.
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              mode_i,
  input  logic signed [lkvc_pkg::DataW-1:0] lookup_key_i,
  input  logic signed [lkvc_pkg::DataW-1:0] write_value_i,
  // Result.
  output logic                              done_o,
  output logic                              hit_o,
  output logic signed [lkvc_pkg::DataW-1:0] read_value_o,
  output logic                              evicted_o,
  output logic signed [lkvc_pkg::DataW-1:0] evicted_key_o
);

  localparam int unsigned DW = lkvc_pkg::DataW;
  // Index of a cell and occupancy count, which must also hold ENTRIES itself.
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OW = $clog2(ENTRIES + 1);
  // Common width for comparing occupancy against the capacity register.
  localparam int unsigned CW = ((OW > lkvc_pkg::CapW) ? OW : lkvc_pkg::CapW) + 1;

  // Capacity register.
  logic [lkvc_pkg::CapW-1:0] capacity_q, capacity_d;

  // Request held while the chain is updated.
  logic                 busy_q, busy_d;
  lkvc_pkg::op_e        mode_q;
  logic [DW-1:0]        key_q;
  logic [DW-1:0]        wval_q;
  logic                 accept;

  // Number of live entries.
  logic [OW-1:0]        occ_q, occ_d;

  // Result registers.
  logic                 done_q, done_d;
  logic                 hit_q, hit_d;
  logic [DW-1:0]        rval_q, rval_d;
  logic                 evicted_q, evicted_d;
  logic [DW-1:0]        evkey_q, evkey_d;

  // Cell chain.
  lkvc_pkg::cell_ctrl_t ctrl       [ENTRIES];
  logic [DW-1:0]        cell_key   [ENTRIES];
  logic [DW-1:0]        cell_value [ENTRIES];
  logic [DW-1:0]        prev_key   [ENTRIES];
  logic [DW-1:0]        prev_value [ENTRIES];
  logic [ENTRIES-1:0]   match;

  // Resolved request.
  logic                 found;
  logic [IW-1:0]        hit_pos;
  logic [DW-1:0]        hit_value;
  logic [DW-1:0]        tail_key;
  logic [CW-1:0]        cap_eff;
  logic                 full;
  logic                 evict;
  logic                 update;
  logic [OW-1:0]        limit;
  logic [DW-1:0]        head_value;

  assign accept = start_i && !busy_q;

  // Clamp the capacity into the range one to ENTRIES.
  always_comb begin
    cap_eff = CW'(capacity_q);
    if (capacity_q == '0) begin
      cap_eff = CW'(1);
    end else if (CW'(capacity_q) > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
  end

  // The chain is ordered by recency, so the least recent entry sits in the last
  // occupied cell. At most one cell matches, hence the plain OR reductions.
  always_comb begin
    found     = 1'b0;
    hit_pos   = '0;
    hit_value = '0;
    tail_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      found     = found | match[i];
      hit_pos   = hit_pos | (match[i] ? IW'(i) : '0);
      hit_value = hit_value | (match[i] ? cell_value[i] : '0);
      tail_key  = tail_key |
                  ((OW'(i) + OW'(1) == occ_q) ? cell_key[i] : '0);
    end
  end

  // A new key evicts when occupancy has reached the capacity, also when the
  // capacity has been lowered below the current occupancy.
  assign full  = (CW'(occ_q) >= cap_eff) || (occ_q == OW'(ENTRIES));
  assign evict = busy_q && !found && (mode_q == lkvc_pkg::OP_PUT) && full;

  // A get that misses leaves the store untouched.
  assign update = busy_q && (found || (mode_q == lkvc_pkg::OP_PUT));

  // Last cell that takes its neighbour's contents.
  always_comb begin
    if (found) begin
      limit = OW'(hit_pos);
    end else if (full) begin
      limit = occ_q - OW'(1);
    end else begin
      limit = occ_q;
    end
  end

  // The head of the chain receives the requested key; a get hit carries its own
  // value back to the front, a put brings the new one.
  assign head_value = (mode_q == lkvc_pkg::OP_PUT) ? wval_q : hit_value;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_key[g]   = key_q;
      assign prev_value[g] = head_value;
    end else begin : g_body
      assign prev_key[g]   = cell_key[g-1];
      assign prev_value[g] = cell_value[g-1];
    end

    assign ctrl[g].compare = accept;
    assign ctrl[g].valid   = OW'(g) < occ_q;
    assign ctrl[g].shift   = update && (OW'(g) <= limit);

    lkvc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[g]),
      .lookup_key_i (lookup_key_i),
      .prev_key_i   (prev_key[g]),
      .prev_value_i (prev_value[g]),
      .key_o        (cell_key[g]),
      .value_o      (cell_value[g]),
      .match_o      (match[g])
    );
  end

  // Occupancy grows only on an insertion that evicts nothing.
  always_comb begin
    occ_d = occ_q;
    if (update && !found && !full) begin
      occ_d = occ_q + OW'(1);
    end
  end

  always_comb begin
    capacity_d = capacity_q;
    if (cfg_we_i) begin
      capacity_d = cfg_wdata_i;
    end
  end

  assign busy_d = accept;

  // Result of the request being resolved in this cycle.
  always_comb begin
    done_d    = busy_q;
    hit_d     = found;
    evicted_d = evict;
    evkey_d   = evict ? tail_key : '0;
    if (mode_q == lkvc_pkg::OP_PUT) begin
      rval_d = '0;
    end else if (found) begin
      rval_d = hit_value;
    end else begin
      rval_d = lkvc_pkg::MissValue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lkvc_pkg::CapacityReset;
      busy_q     <= 1'b0;
      occ_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      capacity_q <= capacity_d;
      busy_q     <= busy_d;
      occ_q      <= occ_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= lkvc_pkg::op_e'(mode_i);
      key_q  <= lookup_key_i;
      wval_q <= write_value_i;
    end
    if (busy_q) begin
      hit_q     <= hit_d;
      rval_q    <= rval_d;
      evicted_q <= evicted_d;
      evkey_q   <= evkey_d;
    end
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign read_value_o  = rval_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evkey_q;

endmodule

@@ rtl/lkvc_cell.sv @@
// One storage cell of the LRU chain: a key, a value and a registered match flag.
// Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lkvc_pkg::cell_ctrl_t        ctrl_i,
  input  logic [lkvc_pkg::DataW-1:0]  lookup_key_i,
  input  logic [lkvc_pkg::DataW-1:0]  prev_key_i,
  input  logic [lkvc_pkg::DataW-1:0]  prev_value_i,
  output logic [lkvc_pkg::DataW-1:0]  key_o,
  output logic [lkvc_pkg::DataW-1:0]  value_o,
  output logic                        match_o
);

  logic [lkvc_pkg::DataW-1:0] key_q, key_d;
  logic [lkvc_pkg::DataW-1:0] value_q, value_d;
  logic                       match_q, match_d;

  // A cell only matches while it holds a live entry.
  always_comb begin
    match_d = match_q;
    if (ctrl_i.compare) begin
      match_d = ctrl_i.valid && (key_q == lookup_key_i);
    end
  end

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      key_d   = prev_key_i;
      value_d = prev_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule
